/* src/ofpf_pkg.sv */
// Shared sizes, request codes, mark codes, pass codes, sequencer states and pass mark helpers of the 1-4 pair finder.
// No dependencies; imported by the top level, not by the RAM.
package ofpf_pkg;

    localparam int MAX_ATOMS   = 256;
    localparam int MAX_BONDS   = 512;
    localparam int MAX_RESULTS = 64;

    localparam int ATOM_W  = 8;
    localparam int CNT_W   = 9;
    localparam int BOND_W  = 2 * ATOM_W;
    localparam int BOND_AW = $clog2(MAX_BONDS);
    localparam int BCNT_W  = $clog2(MAX_BONDS + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int COL_W   = 3;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [COL_W-1:0] COL_BLACK  = 3'd0;
    localparam logic [COL_W-1:0] COL_WHITE  = 3'd1;
    localparam logic [COL_W-1:0] COL_RED    = 3'd2;
    localparam logic [COL_W-1:0] COL_YELLOW = 3'd3;
    localparam logic [COL_W-1:0] COL_BLUE   = 3'd4;

    localparam logic [1:0] PASS_FIRST  = 2'd0;
    localparam logic [1:0] PASS_SECOND = 2'd1;
    localparam logic [1:0] PASS_THIRD  = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INIT   = 8'b0000_0010,
        S_BOND   = 8'b0000_0100,
        S_COLOR  = 8'b0000_1000,
        S_UPDATE = 8'b0001_0000,
        S_SREAD  = 8'b0010_0000,
        S_SCHK   = 8'b0100_0000,
        S_FINAL  = 8'b1000_0000
    } state_t;

    // Mark that a pass spreads from.
    function automatic logic [COL_W-1:0] pass_from(input logic [1:0] pass);
        logic [COL_W-1:0] c;
        begin
            case (pass)
                PASS_FIRST:  c = COL_BLACK;
                PASS_SECOND: c = COL_RED;
                default:     c = COL_BLUE;
            endcase
            return c;
        end
    endfunction

    // Mark that a pass gives to white neighbors.
    function automatic logic [COL_W-1:0] pass_to(input logic [1:0] pass);
        logic [COL_W-1:0] c;
        begin
            case (pass)
                PASS_FIRST:  c = COL_RED;
                PASS_SECOND: c = COL_BLUE;
                default:     c = COL_YELLOW;
            endcase
            return c;
        end
    endfunction

endpackage

/* src/ofpf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the bond list and the mark store; no package dependency.
module ofpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/one_four_pair_finder.sv */
// Top level of the 1-4 pair finder: bond list, mark store and search sequencer.
// Depends on ofpf_pkg and ofpf_ram.
//
// Clear and add requests are taken in the idle state. A search with source atom a
// first sweeps the mark store once at one entry per cycle; one bond memory read
// then starts the first pass (skipped when the list is empty), and each of the
// three passes reads both end marks of a bond from the two mark store copies,
// then does a write-back while the next bond is fetched. The final scan
// reads and checks the marks of atoms a + 1 up to N - 1, where N is the live
// atom count, and ends by loading the last result; it waits while the result
// side stalls. The block takes no new transfer while a search runs; results
// leave through an output register, so the last result may still wait there
// while the next request is taken.
module one_four_pair_finder
    import ofpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,       // atom_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // atom_a [7:0], atom_b [15:8]
    input  logic [1:0]  s_axis_tuser,    // req_type [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // source_atom [7:0], partner_atom [15:8]
    output logic [2:0]  m_axis_tuser,    // pair_valid [0], truncated [1], bad_bond [2]
    output logic        m_axis_tlast
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   atom_count_reg;
    logic [BCNT_W-1:0]  bond_count_reg, bond_count_next;
    logic               bad_reg, bad_next;
    logic [ATOM_W-1:0]  src_reg, src_next;
    logic [CNT_W-1:0]   m_reg, m_next;
    logic [BOND_AW-1:0] i_reg, i_next;
    logic [1:0]         pass_reg, pass_next;
    logic [ATOM_W-1:0]  p_reg, p_next;
    logic [ATOM_W-1:0]  q_reg, q_next;
    logic [ATOM_W-1:0]  pend_reg, pend_next;
    logic [RES_W-1:0]   found_reg, found_next;
    logic               extra_reg, extra_next;

    logic               out_valid_reg, out_valid_next;
    logic [ATOM_W-1:0]  out_src_reg, out_src_next;
    logic [ATOM_W-1:0]  out_partner_reg, out_partner_next;
    logic               out_pv_reg, out_pv_next;
    logic               out_last_reg, out_last_next;
    logic               out_trunc_reg, out_trunc_next;
    logic               out_bad_reg, out_bad_next;

    logic [CNT_W-1:0]   live_n;
    logic               in_xfer;
    logic [ATOM_W-1:0]  in_a;
    logic [ATOM_W-1:0]  in_b;
    logic               out_free;

    logic               bond_we;
    logic [BOND_AW-1:0] bond_waddr;
    logic [BOND_W-1:0]  bond_wdata;
    logic               bond_re;
    logic [BOND_AW-1:0] bond_raddr;
    logic [BOND_W-1:0]  bond_rdata;

    logic               col_we;
    logic [ATOM_W-1:0]  col_waddr;
    logic [COL_W-1:0]   col_wdata;
    logic               col_re;
    logic [ATOM_W-1:0]  col_raddr0;
    logic [ATOM_W-1:0]  col_raddr1;
    logic [COL_W-1:0]   col_rdata0;
    logic [COL_W-1:0]   col_rdata1;

    logic [BCNT_W-1:0]  i_inc;
    logic [COL_W-1:0]   from_c;
    logic [COL_W-1:0]   to_c;

    assign live_n   = (atom_count_reg > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS) : atom_count_reg;
    assign in_a     = s_axis_tdata[ATOM_W-1:0];
    assign in_b     = s_axis_tdata[BOND_W-1:ATOM_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign i_inc    = BCNT_W'(i_reg) + BCNT_W'(1);
    assign from_c   = pass_from(pass_reg);
    assign to_c     = pass_to(pass_reg);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_partner_reg, out_src_reg};
    assign m_axis_tuser  = {out_bad_reg, out_trunc_reg, out_pv_reg};
    assign m_axis_tlast  = out_last_reg;

    ofpf_ram #(
        .WIDTH(BOND_W),
        .DEPTH(MAX_BONDS)
    ) u_bond_ram (
        .clk  (clk),
        .we   (bond_we),
        .waddr(bond_waddr),
        .wdata(bond_wdata),
        .re   (bond_re),
        .raddr(bond_raddr),
        .rdata(bond_rdata)
    );

    // Two copies of the mark store, always written together, so that both
    // ends of a bond are read in one cycle.
    ofpf_ram #(
        .WIDTH(COL_W),
        .DEPTH(MAX_ATOMS)
    ) u_col_ram0 (
        .clk  (clk),
        .we   (col_we),
        .waddr(col_waddr),
        .wdata(col_wdata),
        .re   (col_re),
        .raddr(col_raddr0),
        .rdata(col_rdata0)
    );

    ofpf_ram #(
        .WIDTH(COL_W),
        .DEPTH(MAX_ATOMS)
    ) u_col_ram1 (
        .clk  (clk),
        .we   (col_we),
        .waddr(col_waddr),
        .wdata(col_wdata),
        .re   (col_re),
        .raddr(col_raddr1),
        .rdata(col_rdata1)
    );

    always_comb
    begin
        state_next       = state_reg;
        bond_count_next  = bond_count_reg;
        bad_next         = bad_reg;
        src_next         = src_reg;
        m_next           = m_reg;
        i_next           = i_reg;
        pass_next        = pass_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        pend_next        = pend_reg;
        found_next       = found_reg;
        extra_next       = extra_reg;

        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_src_next     = out_src_reg;
        out_partner_next = out_partner_reg;
        out_pv_next      = out_pv_reg;
        out_last_next    = out_last_reg;
        out_trunc_next   = out_trunc_reg;
        out_bad_next     = out_bad_reg;

        bond_we    = 1'b0;
        bond_waddr = bond_count_reg[BOND_AW-1:0];
        bond_wdata = {in_b, in_a};
        bond_re    = 1'b0;
        bond_raddr = i_reg;

        col_we     = 1'b0;
        col_waddr  = m_reg[ATOM_W-1:0];
        col_wdata  = COL_WHITE;
        col_re     = 1'b0;
        col_raddr0 = m_reg[ATOM_W-1:0];
        col_raddr1 = m_reg[ATOM_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_axis_tuser)
                        REQ_CLEAR:
                        begin
                            bond_count_next = '0;
                            bad_next        = 1'b0;
                        end
                        REQ_ADD:
                        begin
                            if (bond_count_reg >= BCNT_W'(MAX_BONDS)
                                || CNT_W'(in_a) >= live_n || CNT_W'(in_b) >= live_n)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                bond_we         = 1'b1;
                                bond_count_next = bond_count_reg + BCNT_W'(1);
                            end
                        end
                        REQ_SEARCH:
                        begin
                            src_next   = in_a;
                            found_next = '0;
                            extra_next = 1'b0;
                            m_next     = '0;
                            pass_next  = PASS_FIRST;
                            i_next     = '0;
                            // A source beyond the live atoms gives the empty result.
                            state_next = (CNT_W'(in_a) < live_n) ? S_INIT : S_FINAL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                col_we    = 1'b1;
                col_wdata = (m_reg[ATOM_W-1:0] == src_reg) ? COL_BLACK : COL_WHITE;
                m_next    = m_reg + CNT_W'(1);
                if (m_reg == CNT_W'(MAX_ATOMS - 1))
                begin
                    m_next     = CNT_W'(src_reg) + CNT_W'(1);
                    state_next = (bond_count_reg == '0) ? S_SREAD : S_BOND;
                end
            end
            S_BOND:
            begin
                bond_re    = 1'b1;
                bond_raddr = i_reg;
                state_next = S_COLOR;
            end
            S_COLOR:
            begin
                p_next     = bond_rdata[ATOM_W-1:0];
                q_next     = bond_rdata[BOND_W-1:ATOM_W];
                col_re     = 1'b1;
                col_raddr0 = bond_rdata[ATOM_W-1:0];
                col_raddr1 = bond_rdata[BOND_W-1:ATOM_W];
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                col_wdata = to_c;
                if (col_rdata0 == from_c)
                begin
                    if (col_rdata1 == COL_WHITE)
                    begin
                        col_we    = 1'b1;
                        col_waddr = q_reg;
                    end
                end
                else if (col_rdata1 == from_c)
                begin
                    if (col_rdata0 == COL_WHITE)
                    begin
                        col_we    = 1'b1;
                        col_waddr = p_reg;
                    end
                end

                // Fetch the next bond while the marks are written back.
                if (i_inc < bond_count_reg)
                begin
                    i_next     = i_inc[BOND_AW-1:0];
                    bond_re    = 1'b1;
                    bond_raddr = i_inc[BOND_AW-1:0];
                    state_next = S_COLOR;
                end
                else if (pass_reg == PASS_THIRD)
                begin
                    state_next = S_SREAD;
                end
                else
                begin
                    pass_next  = pass_reg + 2'd1;
                    i_next     = '0;
                    bond_re    = 1'b1;
                    bond_raddr = '0;
                    state_next = S_COLOR;
                end
            end
            S_SREAD:
            begin
                if (m_reg < live_n)
                begin
                    col_re     = 1'b1;
                    col_raddr0 = m_reg[ATOM_W-1:0];
                    state_next = S_SCHK;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_SCHK:
            begin
                if (col_rdata0 != COL_YELLOW)
                begin
                    m_next     = m_reg + CNT_W'(1);
                    state_next = S_SREAD;
                end
                else if (found_reg >= RES_W'(MAX_RESULTS))
                begin
                    extra_next = 1'b1;
                    m_next     = m_reg + CNT_W'(1);
                    state_next = S_SREAD;
                end
                else if (found_reg == '0)
                begin
                    pend_next  = m_reg[ATOM_W-1:0];
                    found_next = RES_W'(1);
                    m_next     = m_reg + CNT_W'(1);
                    state_next = S_SREAD;
                end
                else if (out_free)
                begin
                    // The held partner is not the last one: send it on.
                    out_valid_next   = 1'b1;
                    out_src_next     = src_reg;
                    out_partner_next = pend_reg;
                    out_pv_next      = 1'b1;
                    out_last_next    = 1'b0;
                    out_trunc_next   = 1'b0;
                    out_bad_next     = bad_reg;
                    pend_next        = m_reg[ATOM_W-1:0];
                    found_next       = found_reg + RES_W'(1);
                    m_next           = m_reg + CNT_W'(1);
                    state_next       = S_SREAD;
                end
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_src_next     = src_reg;
                    out_last_next    = 1'b1;
                    out_bad_next     = bad_reg;
                    if (found_reg == '0)
                    begin
                        out_partner_next = '0;
                        out_pv_next      = 1'b0;
                        out_trunc_next   = 1'b0;
                    end
                    else
                    begin
                        out_partner_next = pend_reg;
                        out_pv_next      = 1'b1;
                        out_trunc_next   = extra_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            atom_count_reg <= CNT_W'(MAX_ATOMS);
            bond_count_reg <= '0;
            bad_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            found_reg      <= '0;
            extra_reg      <= 1'b0;
            m_reg          <= '0;
            i_reg          <= '0;
            pass_reg       <= PASS_FIRST;
        end
        else
        begin
            state_reg      <= state_next;
            bond_count_reg <= bond_count_next;
            bad_reg        <= bad_next;
            out_valid_reg  <= out_valid_next;
            found_reg      <= found_next;
            extra_reg      <= extra_next;
            m_reg          <= m_next;
            i_reg          <= i_next;
            pass_reg       <= pass_next;
            if (cfg_we)
            begin
                atom_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg         <= src_next;
        p_reg           <= p_next;
        q_reg           <= q_next;
        pend_reg        <= pend_next;
        out_src_reg     <= out_src_next;
        out_partner_reg <= out_partner_next;
        out_pv_reg      <= out_pv_next;
        out_last_reg    <= out_last_next;
        out_trunc_reg   <= out_trunc_next;
        out_bad_reg     <= out_bad_next;
    end

endmodule
